// ===== rtl/itoa_pkg.sv =====
`default_nettype none
package itoa_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int MAX_DIGITS    = 32;
  localparam int RADIX_W       = 6;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W         = $clog2(MAX_DIGITS);
  localparam int BITS_PER_STEP = 8;
  localparam int STEPS         = VALUE_BITS / BITS_PER_STEP;
  localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0]         RADIX_ADDR  = 3'd0;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'h57;
  localparam logic [CHAR_W-1:0]  CHAR_NONE   = 7'h00;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);

  typedef struct packed {
    logic                  bad;
    logic                  neg;
    logic [RADIX_W-1:0]    radix;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  // digit value to lower-case ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] v);
    logic [CHAR_W-1:0] c;
    if (v < DIGIT_TEN) c = CHAR_ZERO + CHAR_W'(v);
    else c = CHAR_ALPHA + CHAR_W'(v);
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/itoa_front.sv =====
`default_nettype none
module itoa_front (
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic signed [itoa_pkg::VALUE_BITS-1:0] number,
  input  wire logic [itoa_pkg::RADIX_W-1:0]       radix,
  input  wire logic                               queue_full,
  output logic                                    push,
  output itoa_pkg::job_t                          job
);

  logic [itoa_pkg::VALUE_BITS-1:0] raw;

  assign raw        = number;
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    job.bad   = (radix < itoa_pkg::RADIX_MIN) || (radix > itoa_pkg::RADIX_MAX);
    job.neg   = raw[itoa_pkg::VALUE_BITS-1];
    job.radix = radix;
    job.mag   = raw[itoa_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  end

endmodule
`default_nettype wire

// ===== rtl/itoa_queue.sv =====
`default_nettype none
module itoa_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  itoa_pkg::job_t      push_job,
  input  wire logic           pop,
  output itoa_pkg::job_t      pop_job,
  output logic                full,
  output logic                empty
);

  itoa_pkg::job_t                  slots [itoa_pkg::QUEUE_DEPTH];
  logic [itoa_pkg::QPTR_W-1:0]     wptr;
  logic [itoa_pkg::QPTR_W-1:0]     rptr;
  logic [itoa_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == itoa_pkg::QCNT_W'(itoa_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/itoa_back.sv =====
`default_nettype none
module itoa_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  itoa_pkg::job_t                   job,
  input  wire logic                        queue_empty,
  output logic                             pop,
  output logic                             char_valid,
  input  wire logic                        char_stall,
  output logic [itoa_pkg::CHAR_W-1:0]      char_code,
  output logic                             last_char,
  output logic                             bad_radix
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT, S_BAD} state_t;

  state_t                              state;
  logic [itoa_pkg::VALUE_BITS-1:0]     quo;
  logic [itoa_pkg::DIGIT_W-1:0]        rem;
  logic [itoa_pkg::RADIX_W-1:0]        radix;
  logic                                sign_pending;
  logic [itoa_pkg::STEP_W-1:0]         step;
  logic [itoa_pkg::CNT_W-1:0]          count;
  logic [itoa_pkg::DIGIT_W-1:0]        digit_store [itoa_pkg::MAX_DIGITS];

  logic [itoa_pkg::VALUE_BITS-1:0]     quo_next;
  logic [itoa_pkg::DIGIT_W-1:0]        rem_next;
  logic [itoa_pkg::CNT_W-1:0]          count_inc;
  logic [itoa_pkg::IDX_W-1:0]          rd_idx;
  logic                                out_free;
  logic                                emit;

  assign out_free  = !char_valid || !char_stall;
  assign emit      = ((state == S_EMIT) || (state == S_BAD)) && out_free;
  assign pop       = (state == S_IDLE) && !queue_empty;
  assign count_inc = count + 1'b1;
  assign rd_idx    = itoa_pkg::IDX_W'(count - 1'b1);

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [itoa_pkg::DIGIT_W:0]      t;
    logic [itoa_pkg::DIGIT_W-1:0]    r;
    logic [itoa_pkg::VALUE_BITS-1:0] q;
    r = rem;
    q = quo;
    for (int k = 0; k < itoa_pkg::BITS_PER_STEP; k++) begin
      t = {r, q[itoa_pkg::VALUE_BITS-1]};
      q = {q[itoa_pkg::VALUE_BITS-2:0], 1'b0};
      if (t >= {1'b0, radix}) begin
        t    = t - {1'b0, radix};
        q[0] = 1'b1;
      end
      r = t[itoa_pkg::DIGIT_W-1:0];
    end
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && step == itoa_pkg::STEP_W'(itoa_pkg::STEPS - 1))
      digit_store[count[itoa_pkg::IDX_W-1:0]] <= rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      char_valid   <= 1'b0;
      quo          <= '0;
      rem          <= '0;
      radix        <= '0;
      sign_pending <= 1'b0;
      step         <= '0;
      count        <= '0;
      char_code    <= '0;
      last_char    <= 1'b0;
      bad_radix    <= 1'b0;
    end else begin
      if (emit) char_valid <= 1'b1;
      else if (!char_stall) char_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            if (job.bad) begin
              state <= S_BAD;
            end else begin
              quo          <= job.mag;
              rem          <= '0;
              radix        <= job.radix;
              sign_pending <= job.neg;
              step         <= '0;
              count        <= '0;
              state        <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo <= quo_next;
          if (step == itoa_pkg::STEP_W'(itoa_pkg::STEPS - 1)) begin
            count <= count_inc;
            step  <= '0;
            rem   <= '0;
            if (quo_next == '0 || count_inc == itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS))
              state <= S_EMIT;
          end else begin
            step <= step + 1'b1;
            rem  <= rem_next;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            bad_radix  <= 1'b0;
            if (sign_pending) begin
              sign_pending <= 1'b0;
              char_code    <= itoa_pkg::CHAR_MINUS;
              last_char    <= 1'b0;
            end else begin
              char_code <= itoa_pkg::digit_char(digit_store[rd_idx]);
              last_char <= (count == itoa_pkg::CNT_W'(1));
              count     <= count - 1'b1;
              if (count == itoa_pkg::CNT_W'(1)) state <= S_IDLE;
            end
          end
        end
        S_BAD: begin
          if (out_free) begin
            char_code  <= itoa_pkg::CHAR_NONE;
            last_char  <= 1'b1;
            bad_radix  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_radix.sv =====
`default_nettype none
// New numbers enter a two-entry job queue while it is not full. When idle, the
// converter pops a job and divides by the radix, one digit per division (the
// divider retires 8 quotient bits a cycle), then sends a minus sign if negative
// and the digits, most significant first, one character a cycle unless stalled.
// Synchronous active-high reset empties the queue, idles the converter and sets
// radix to 10; the digit store is not cleared.
module integer_to_ascii_radix (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [2:0]                             paddr,
  input  wire logic [31:0]                            pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready,
  input  wire logic                                   item_valid,
  output logic                                        item_stall,
  input  wire logic signed [itoa_pkg::VALUE_BITS-1:0] number,
  output logic                                        char_valid,
  input  wire logic                                   char_stall,
  output logic [itoa_pkg::CHAR_W-1:0]                 char_code,
  output logic                                        last_char,
  output logic                                        bad_radix
);

  logic [itoa_pkg::RADIX_W-1:0] radix;
  logic                         push;
  logic                         pop;
  logic                         queue_full;
  logic                         queue_empty;
  itoa_pkg::job_t               push_job;
  itoa_pkg::job_t               pop_job;

  assign pready = 1'b1;
  assign prdata = (paddr == itoa_pkg::RADIX_ADDR) ?
                  {{(32 - itoa_pkg::RADIX_W){1'b0}}, radix} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itoa_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && paddr == itoa_pkg::RADIX_ADDR) begin
      radix <= pwdata[itoa_pkg::RADIX_W-1:0];
    end
  end

  itoa_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .number     (number),
    .radix      (radix),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  itoa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  itoa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (pop_job),
    .queue_empty (queue_empty),
    .pop         (pop),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .last_char   (last_char),
    .bad_radix   (bad_radix)
  );

endmodule
`default_nettype wire
